/* sv/cfmf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the camera frame mode filter.
// Used by every module of the block; depends on nothing.
package cfmf_pkg;

  localparam logic [7:0]  START_BYTE = 8'd42;
  localparam logic [15:0] NO_READING = 16'd65506;

  // Six 16-bit words are kept from each frame.
  localparam int WORD_COUNT  = 6;
  localparam int BYTE_IDX_W  = 6;
  localparam int WORD_IDX_W  = 3;

  localparam int W_BALL_ANGLE     = 0;
  localparam int W_BALL_STRENGTH  = 1;
  localparam int W_YELLOW_ANGLE   = 2;
  localparam int W_YELLOW_STRENGTH = 3;
  localparam int W_BLUE_ANGLE     = 4;
  localparam int W_BLUE_STRENGTH  = 5;

  typedef logic [WORD_COUNT-1:0][15:0] frame_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_SCAN,
    BK_PICK,
    BK_OUT
  } back_state_t;

endpackage

/* sv/camera_frame_mode_filter.sv */
`timescale 1ns / 1ps
// Top level of the camera frame mode filter.
// Depends on cfmf_pkg, cfmf_front, cfmf_queue and cfmf_back.
//
//   Channel  Direction  Contents
//   in_      slave      tdata[7:0] = rx_byte
//   out_     master     tdata = ball_angle, ball_strength, yellow_goal_angle,
//                       yellow_goal_strength, blue_goal_angle,
//                       blue_goal_strength; tuser[0] = attacking_yellow
//   cfg_     write      cfg_wr_data = attack_side
//
// Rates: the assembler takes one byte word per cycle, except that the last
// byte of a frame waits for room in the queue; a frame is FRAME_BYTES + 1
// words including the start byte. A frame whose ball pair is present goes
// straight to the output register; for any other the filter walks the
// history with its single compare unit, one entry pair per cycle.
// Reset (rst_n, synchronous, active low) fills the history with the missing
// marker and returns the assembler to hunting for the start byte.
// A two-frame queue lets the assembler keep taking bytes while the filter
// works or the result waits in the output register.

module camera_frame_mode_filter #(
  parameter int HISTORY_DEPTH = 8,
  parameter int FRAME_BYTES   = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input words: [7:0] rx_byte.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,
  // Result words: [15:0] ball_angle, [31:16] ball_strength,
  // [47:32] yellow_goal_angle, [63:48] yellow_goal_strength,
  // [79:64] blue_goal_angle, [95:80] blue_goal_strength.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,
  // Result flags: [0] attacking_yellow.
  output logic [0:0]   out_tuser,
  // Attack side register, written whenever cfg_wr_en is high.
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data
);

  logic             attack_side_r;
  logic             push_valid, push_ready;
  cfmf_pkg::frame_t push_frame;
  logic             pop_valid, pop_ready;
  cfmf_pkg::frame_t pop_frame;
  cfmf_pkg::frame_t out_frame;
  logic             out_attack;

  // The attack side must be changed only while the block is idle; the
  // block does not enforce it. Sampled when a result loads the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_side_r <= 1'b0;
    end else if (cfg_wr_en) begin
      attack_side_r <= cfg_wr_data;
    end
  end

  cfmf_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_ready (in_tready),
    .byte_data  (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame)
  );

  cfmf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame)
  );

  cfmf_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_frame   (pop_frame),
    .attack_side (attack_side_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_frame   (out_frame),
    .out_attack  (out_attack)
  );

  // Word 0 of the frame lands in the lowest bits of the result.
  assign out_tdata = out_frame;
  assign out_tuser = out_attack;

endmodule

/* sv/cfmf_front.sv */
`timescale 1ns / 1ps
// Frame assembler: hunts for the start byte and pairs bytes into words.
// Depends on cfmf_pkg; pushes finished frames into cfmf_queue.
module cfmf_front #(
  parameter int FRAME_BYTES = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic [7:0]        byte_data,
  output logic              push_valid,
  input  logic              push_ready,
  output cfmf_pkg::frame_t  push_frame
);

  logic                              in_frame_r, in_frame_nxt;
  logic [cfmf_pkg::BYTE_IDX_W-1:0]   byte_idx_r, byte_idx_nxt;
  logic [7:0]                        hold_r, hold_nxt;
  cfmf_pkg::frame_t                  words_r, words_nxt;
  logic                              last_byte;
  logic                              take;
  logic [cfmf_pkg::BYTE_IDX_W-2:0]   word_idx;

  assign last_byte  = (byte_idx_r == cfmf_pkg::BYTE_IDX_W'(FRAME_BYTES - 1));
  assign byte_ready = !(in_frame_r && last_byte) || push_ready;
  assign take       = byte_valid && byte_ready;
  assign word_idx   = byte_idx_r[cfmf_pkg::BYTE_IDX_W-1:1];

  always_comb begin
    in_frame_nxt = in_frame_r;
    byte_idx_nxt = byte_idx_r;
    hold_nxt     = hold_r;
    words_nxt    = words_r;
    push_valid   = 1'b0;
    if (take) begin
      if (!in_frame_r) begin
        if (byte_data == cfmf_pkg::START_BYTE) begin
          in_frame_nxt = 1'b1;
          byte_idx_nxt = '0;
        end
      end else begin
        if (!byte_idx_r[0]) begin
          hold_nxt = byte_data;
        end else if (word_idx < (cfmf_pkg::BYTE_IDX_W-1)'(cfmf_pkg::WORD_COUNT)) begin
          words_nxt[word_idx[cfmf_pkg::WORD_IDX_W-1:0]] = {hold_r, byte_data};
        end
        if (last_byte) begin
          in_frame_nxt = 1'b0;
          byte_idx_nxt = '0;
          push_valid   = 1'b1;
        end else begin
          byte_idx_nxt = byte_idx_r + 1'b1;
        end
      end
    end
  end

  // The pushed frame includes the word completed by the final byte.
  assign push_frame = words_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      byte_idx_r <= '0;
      hold_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      byte_idx_r <= byte_idx_nxt;
      hold_r     <= hold_nxt;
    end
    words_r <= words_nxt;
  end

endmodule

/* sv/cfmf_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of assembled frames between the assembler and the filter.
// Depends on cfmf_pkg for the frame type.
module cfmf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  cfmf_pkg::frame_t  push_frame,
  output logic              pop_valid,
  input  logic              pop_ready,
  output cfmf_pkg::frame_t  pop_frame
);

  cfmf_pkg::frame_t mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_frame  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

/* sv/cfmf_back.sv */
`timescale 1ns / 1ps
// Ball history, mode filter and result register.
// Depends on cfmf_pkg; pops frames from cfmf_queue.
module cfmf_back #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  cfmf_pkg::frame_t  pop_frame,
  input  logic              attack_side,
  output logic              out_valid,
  input  logic              out_ready,
  output cfmf_pkg::frame_t  out_frame,
  output logic              out_attack
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  cfmf_pkg::back_state_t state_r, state_nxt;

  logic [15:0] hist_a_r [HISTORY_DEPTH];
  logic [15:0] hist_d_r [HISTORY_DEPTH];
  logic [15:0] scan_a_r [HISTORY_DEPTH];
  logic [15:0] scan_d_r [HISTORY_DEPTH];

  logic [CNT_W-1:0] i_r, rem_r;
  logic [CNT_W-1:0] cnt_a_r, cnt_d_r, best_a_r, best_d_r;
  logic [15:0]      key_a_r, key_d_r, mode_a_r, mode_d_r;
  logic             cand_r;
  cfmf_pkg::frame_t res_r;
  cfmf_pkg::frame_t out_frame_r;
  logic             out_valid_r, out_attack_r;

  logic        take, need_mode, out_load, last_pick;
  logic        win_a, win_d;
  logic [15:0] pick_a, pick_d;

  assign need_mode = (pop_frame[cfmf_pkg::W_BALL_ANGLE] == cfmf_pkg::NO_READING) ||
                     (pop_frame[cfmf_pkg::W_BALL_STRENGTH] == cfmf_pkg::NO_READING);
  assign last_pick = (i_r == CNT_W'(HISTORY_DEPTH - 1));
  assign win_a     = cand_r && (cnt_a_r >= best_a_r);
  assign win_d     = cand_r && (cnt_d_r >= best_d_r);
  assign pick_a    = win_a ? key_a_r : mode_a_r;
  assign pick_d    = win_d ? key_d_r : mode_d_r;

  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    take      = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      cfmf_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          take      = 1'b1;
          state_nxt = need_mode ? cfmf_pkg::BK_LOAD : cfmf_pkg::BK_OUT;
        end
      end
      cfmf_pkg::BK_LOAD: begin
        state_nxt = cfmf_pkg::BK_SCAN;
      end
      cfmf_pkg::BK_SCAN: begin
        if (rem_r == CNT_W'(1)) begin
          state_nxt = cfmf_pkg::BK_PICK;
        end
      end
      cfmf_pkg::BK_PICK: begin
        state_nxt = last_pick ? cfmf_pkg::BK_OUT : cfmf_pkg::BK_LOAD;
      end
      cfmf_pkg::BK_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = cfmf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = cfmf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfmf_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_a_r[k] <= cfmf_pkg::NO_READING;
        hist_d_r[k] <= cfmf_pkg::NO_READING;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        // Newest pair enters at the end of the window.
        for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
          hist_a_r[k] <= hist_a_r[k+1];
          hist_d_r[k] <= hist_d_r[k+1];
        end
        hist_a_r[HISTORY_DEPTH-1] <= pop_frame[cfmf_pkg::W_BALL_ANGLE];
        hist_d_r[HISTORY_DEPTH-1] <= pop_frame[cfmf_pkg::W_BALL_STRENGTH];
      end else if (state_r == cfmf_pkg::BK_PICK) begin
        // Rotate by one; after a full pass the window is back in place.
        for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
          hist_a_r[k] <= hist_a_r[k+1];
          hist_d_r[k] <= hist_d_r[k+1];
        end
        hist_a_r[HISTORY_DEPTH-1] <= hist_a_r[0];
        hist_d_r[HISTORY_DEPTH-1] <= hist_d_r[0];
      end
    end

    if (take) begin
      res_r    <= pop_frame;
      i_r      <= '0;
      best_a_r <= '0;
      best_d_r <= '0;
      mode_a_r <= cfmf_pkg::NO_READING;
      mode_d_r <= cfmf_pkg::NO_READING;
    end

    if (state_r == cfmf_pkg::BK_LOAD) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        scan_a_r[k] <= hist_a_r[k];
        scan_d_r[k] <= hist_d_r[k];
      end
      key_a_r <= hist_a_r[0];
      key_d_r <= hist_d_r[0];
      cand_r  <= (hist_a_r[0] != cfmf_pkg::NO_READING) &&
                 (hist_d_r[0] != cfmf_pkg::NO_READING);
      cnt_a_r <= '0;
      cnt_d_r <= '0;
      rem_r   <= CNT_W'(HISTORY_DEPTH) - i_r;
    end

    if (state_r == cfmf_pkg::BK_SCAN) begin
      cnt_a_r <= cnt_a_r + CNT_W'(scan_a_r[0] == key_a_r);
      cnt_d_r <= cnt_d_r + CNT_W'(scan_d_r[0] == key_d_r);
      for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
        scan_a_r[k] <= scan_a_r[k+1];
        scan_d_r[k] <= scan_d_r[k+1];
      end
      rem_r <= rem_r - CNT_W'(1);
    end

    if (state_r == cfmf_pkg::BK_PICK) begin
      if (win_a) begin
        best_a_r <= cnt_a_r;
      end
      if (win_d) begin
        best_d_r <= cnt_d_r;
      end
      mode_a_r <= pick_a;
      mode_d_r <= pick_d;
      i_r      <= i_r + CNT_W'(1);
      if (last_pick) begin
        res_r[cfmf_pkg::W_BALL_ANGLE]    <= pick_a;
        res_r[cfmf_pkg::W_BALL_STRENGTH] <= pick_d;
      end
    end

    if (out_load) begin
      out_frame_r  <= res_r;
      out_attack_r <= attack_side;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_frame  = out_frame_r;
  assign out_attack = out_attack_r;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for camera_frame_mode_filter: drives serial bytes,
// predicts every decoded frame and compares each result word field by field.
// Depends on cfmf_pkg and the camera_frame_mode_filter RTL only.

module testbench;

  // Block configuration under test. The predictor uses the same sizes.
  localparam int HIST_DEPTH  = 8;
  localparam int FRAME_LEN   = 12;

  // Cycles allowed after the last result before the register may change.
  // A history walk must fit in it, and up to two frames can be queued.
  localparam int SETTLE_CYCLES = 160;

  // Ball angle and distance results, plus the four goal words, as the block
  // reports them for one complete frame.
  typedef struct {
    logic [15:0] ball_angle;
    logic [15:0] ball_strength;
    logic [15:0] yellow_angle;
    logic [15:0] yellow_strength;
    logic [15:0] blue_angle;
    logic [15:0] blue_strength;
    logic        attacking_yellow;
  } camera_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  camera_frame_mode_filter #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .FRAME_BYTES  (FRAME_LEN)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Frame decoder predictor state. It mirrors what the block should hold:
  // the ball history window, the frame assembler and the attack side.
  // ---------------------------------------------------------------------
  logic [15:0] angle_window [HIST_DEPTH];
  logic [15:0] dist_window  [HIST_DEPTH];
  bit          frame_open = 1'b0;
  int unsigned byte_pos = 0;
  logic [15:0] frame_word [cfmf_pkg::WORD_COUNT];
  logic [7:0]  high_byte = 8'd0;
  bit          attack_yellow_cfg = 1'b0;

  camera_result_t expected_frames [$];
  logic [7:0]     pending_bytes [$];

  // Bookkeeping shared by the driver, monitor and stimulus.
  int          error_count = 0;
  int          results_seen = 0;
  int          frames_filtered = 0;
  int          frame_bytes_sent = 0;
  int          input_stall_cycles = 0;
  int          in_gap_max = 15;
  int          out_gap_max = 15;
  int          out_hold_left = 0;
  bit          byte_taken = 1'b0;
  bit          result_taken = 1'b0;
  int          in_gap_left = 0;
  int          out_wait_left = 0;
  camera_result_t head_result;

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      angle_window[i] = cfmf_pkg::NO_READING;
      dist_window[i]  = cfmf_pkg::NO_READING;
    end
    for (int i = 0; i < cfmf_pkg::WORD_COUNT; i++) frame_word[i] = 16'd0;
  end

  // Mode over the history window for angle (pick_angle = 1) or distance.
  // Only entries with both readings present can win. Each candidate counts
  // matches from its own slot to the newest, and a tie goes to the newer
  // candidate.
  function automatic logic [15:0] window_mode_of(input bit pick_angle);
    int unsigned best_count;
    int unsigned hits;
    logic [15:0] winner;
    logic [15:0] probe;
    logic [15:0] other;
    best_count = 0;
    winner = cfmf_pkg::NO_READING;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (angle_window[i] != cfmf_pkg::NO_READING &&
          dist_window[i] != cfmf_pkg::NO_READING) begin
        probe = pick_angle ? angle_window[i] : dist_window[i];
        hits = 0;
        for (int j = i; j < HIST_DEPTH; j++) begin
          other = pick_angle ? angle_window[j] : dist_window[j];
          if (other == probe) hits++;
        end
        if (hits >= best_count) begin
          best_count = hits;
          winner = probe;
        end
      end
    end
    return winner;
  endfunction

  // Advances the predictor by one accepted serial byte and queues the
  // expected result when the byte completes a frame.
  function automatic void decode_rx_byte(input logic [7:0] rx);
    camera_result_t res;
    int unsigned word_sel;
    if (!frame_open) begin
      // While hunting, everything except the start byte is dropped.
      if (rx == cfmf_pkg::START_BYTE) begin
        frame_open = 1'b1;
        byte_pos = 0;
      end
      return;
    end
    // Inside a frame a start byte is plain data; there is no resync.
    word_sel = byte_pos >> 1;
    if (byte_pos[0] == 1'b0) begin
      high_byte = rx;
    end else if (word_sel < cfmf_pkg::WORD_COUNT) begin
      frame_word[word_sel] = {high_byte, rx};
    end
    if (byte_pos + 1 < FRAME_LEN) begin
      byte_pos = (byte_pos + 1) & 63;
      return;
    end
    frame_open = 1'b0;
    byte_pos = 0;
    for (int i = 0; i + 1 < HIST_DEPTH; i++) begin
      angle_window[i] = angle_window[i + 1];
      dist_window[i]  = dist_window[i + 1];
    end
    angle_window[HIST_DEPTH - 1] = frame_word[cfmf_pkg::W_BALL_ANGLE];
    dist_window[HIST_DEPTH - 1]  = frame_word[cfmf_pkg::W_BALL_STRENGTH];
    // A missing angle or distance replaces both with the window modes.
    if (frame_word[cfmf_pkg::W_BALL_ANGLE] == cfmf_pkg::NO_READING ||
        frame_word[cfmf_pkg::W_BALL_STRENGTH] == cfmf_pkg::NO_READING) begin
      res.ball_angle    = window_mode_of(1'b1);
      res.ball_strength = window_mode_of(1'b0);
      frames_filtered++;
    end else begin
      res.ball_angle    = frame_word[cfmf_pkg::W_BALL_ANGLE];
      res.ball_strength = frame_word[cfmf_pkg::W_BALL_STRENGTH];
    end
    res.yellow_angle     = frame_word[cfmf_pkg::W_YELLOW_ANGLE];
    res.yellow_strength  = frame_word[cfmf_pkg::W_YELLOW_STRENGTH];
    res.blue_angle       = frame_word[cfmf_pkg::W_BLUE_ANGLE];
    res.blue_strength    = frame_word[cfmf_pkg::W_BLUE_STRENGTH];
    res.attacking_yellow = attack_yellow_cfg;
    expected_frames.push_back(res);
  endfunction

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
    error_count++;
  endtask

  task automatic compare_word(input string name, input logic [15:0] got,
                              input logic [15:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Input driver. The rising edge records an accepted word and feeds the
  // predictor; the falling edge presents the next byte after a random gap.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      byte_taken = 1'b1;
      decode_rx_byte(in_tdata);
    end
    if (rst_n && in_tvalid && !in_tready) input_stall_cycles++;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || byte_taken) begin
      byte_taken = 1'b0;
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_tdata <= pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_gap_left = $urandom_range(0, in_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor. Every accepted result word is checked against the
  // oldest predicted frame; the ready side stalls for a random count after
  // each word and during any long hold-off.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_taken = 1'b1;
      results_seen++;
      if (expected_frames.size() == 0) begin
        log_mismatch("result word arrived with no frame pending");
      end else begin
        head_result = expected_frames.pop_front();
        compare_word("ball_angle",
                     out_tdata[16*cfmf_pkg::W_BALL_ANGLE +: 16],
                     head_result.ball_angle);
        compare_word("ball_strength",
                     out_tdata[16*cfmf_pkg::W_BALL_STRENGTH +: 16],
                     head_result.ball_strength);
        compare_word("yellow_goal_angle",
                     out_tdata[16*cfmf_pkg::W_YELLOW_ANGLE +: 16],
                     head_result.yellow_angle);
        compare_word("yellow_goal_strength",
                     out_tdata[16*cfmf_pkg::W_YELLOW_STRENGTH +: 16],
                     head_result.yellow_strength);
        compare_word("blue_goal_angle",
                     out_tdata[16*cfmf_pkg::W_BLUE_ANGLE +: 16],
                     head_result.blue_angle);
        compare_word("blue_goal_strength",
                     out_tdata[16*cfmf_pkg::W_BLUE_STRENGTH +: 16],
                     head_result.blue_strength);
        compare_word("attacking_yellow", {15'd0, out_tuser[0]},
                     {15'd0, head_result.attacking_yellow});
      end
    end
  end

  // The long receiver hold-off counts down in its own process.
  always @(posedge clk) begin
    if (out_hold_left > 0) out_hold_left <= out_hold_left - 1;
  end

  always @(negedge clk) begin
    if (result_taken) begin
      result_taken = 1'b0;
      out_wait_left = $urandom_range(0, out_gap_max);
    end
    if (!rst_n || out_hold_left > 0) begin
      out_tready <= 1'b0;
    end else if (out_wait_left > 0) begin
      out_wait_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Any byte except the start byte, for noise while hunting and filler.
  function automatic logic [7:0] plain_byte();
    int unsigned b;
    b = $urandom_range(0, 254);
    if (b >= cfmf_pkg::START_BYTE) b++;
    return b[7:0];
  endfunction

  // Ball readings lean on a small pool so that the history repeats values
  // and the mode has real ties and majorities to resolve.
  function automatic logic [15:0] pick_ball_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return cfmf_pkg::NO_READING;
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return 16'd0;
        1: return 16'd90;
        2: return 16'd270;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // One well-formed frame: start byte, then six big-endian words.
  task automatic push_frame(input logic [15:0] angle, input logic [15:0] ball_dist,
                            input logic [15:0] ya, input logic [15:0] ys,
                            input logic [15:0] ba, input logic [15:0] bs);
    logic [15:0] words [cfmf_pkg::WORD_COUNT];
    words = '{angle, ball_dist, ya, ys, ba, bs};
    pending_bytes.push_back(cfmf_pkg::START_BYTE);
    foreach (words[i]) begin
      pending_bytes.push_back(words[i][15:8]);
      pending_bytes.push_back(words[i][7:0]);
    end
    frame_bytes_sent += 1 + 2 * cfmf_pkg::WORD_COUNT;
  endtask

  // A random frame, sometimes preceded by noise bytes or by a truncated
  // frame that swallows the following start byte as data.
  task automatic push_random_frame();
    logic [15:0] goal [4];
    int unsigned r;
    int unsigned cut;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(1, 3)) pending_bytes.push_back(plain_byte());
    end else if (r < 20) begin
      cut = $urandom_range(0, FRAME_LEN - 1);
      pending_bytes.push_back(cfmf_pkg::START_BYTE);
      repeat (cut) pending_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes_sent += 1 + cut;
    end
    foreach (goal[i]) begin
      case ($urandom_range(0, 9))
        0: goal[i] = 16'h0000;
        1: goal[i] = 16'hFFFF;
        2: goal[i] = {cfmf_pkg::START_BYTE, cfmf_pkg::START_BYTE};
        default: goal[i] = 16'($urandom_range(0, 65535));
      endcase
    end
    push_frame(pick_ball_word(), pick_ball_word(), goal[0], goal[1], goal[2], goal[3]);
  endtask

  // Waits until every queued byte is taken and every predicted result has
  // been checked.
  task automatic drain_results();
    while (pending_bytes.size() > 0 || in_tvalid || expected_frames.size() > 0)
      @(posedge clk);
  endtask

  // Brings the block to idle for a register write: a frame left open by a
  // truncated sequence is closed with filler bytes, then the filter is
  // given time to finish any walk still under way.
  task automatic settle_block();
    drain_results();
    while (frame_open) begin
      repeat (FRAME_LEN - byte_pos) pending_bytes.push_back(plain_byte());
      drain_results();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_attack_side(input bit side);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= side;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    attack_yellow_cfg = side;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_attack_side(1'b1);

    // Directed: noise while hunting, a frame with a missing angle while the
    // history is still empty, then a frame of extreme values whose data
    // carries the start byte.
    in_gap_max = 0;
    out_gap_max = 0;
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h00);
    push_frame(cfmf_pkg::NO_READING, 16'h1234, 16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE);
    push_frame(16'hFFFF, 16'h0000, {cfmf_pkg::START_BYTE, cfmf_pkg::START_BYTE},
               16'h002A, 16'hFFFF, 16'h0000);
    settle_block();
    set_attack_side(1'b0);

    // Random frames with random gaps on both sides.
    in_gap_max = 15;
    out_gap_max = 15;
    while (frame_bytes_sent < 500) push_random_frame();
    settle_block();
    set_attack_side(1'b1);

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender streams without gaps, so the frame queue fills and in_tready
    // drops.
    in_gap_max = 0;
    out_gap_max = 3;
    out_hold_left = 2500;
    while (frame_bytes_sent < 1000) push_random_frame();
    settle_block();
    set_attack_side(1'b0);

    // Mixed pacing. Every twelve frames the sender pauses until all
    // results are back, and the gap ranges change between bursts and idles.
    for (int n = 0; frame_bytes_sent < 1500; n++) begin
      if (n % 12 == 0) begin
        drain_results();
        in_gap_max  = ($urandom_range(0, 1) == 0) ? 0 : 15;
        out_gap_max = ($urandom_range(0, 1) == 0) ? 0 : 15;
      end
      push_random_frame();
    end
    settle_block();
    set_attack_side(1'b1);

    in_gap_max = 15;
    out_gap_max = 15;
    while (frame_bytes_sent < 1650) push_random_frame();
    settle_block();

    $display("Sent %0d frame bytes; checked %0d results, %0d of them mode-filtered.",
             frame_bytes_sent, results_seen, frames_filtered);
    $display("Input was held off for %0d cycles; attack side took both values.",
             input_stall_cycles);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("Timeout: %0d results still expected", expected_frames.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
